// ===== rtl/qcpm_pkg.sv =====
`default_nettype none

package qcpm_pkg;

  // Item layout.
  localparam int NUM_IN_FIELDS   = 12;
  localparam int NUM_OUT_FIELDS  = 4;
  localparam int CMD_W           = 16;
  localparam int VALUE_FRAC_BITS = 12;
  localparam int GAIN_INT_BITS   = 4;

  // Input field positions inside the slave tdata, counted in values.
  localparam int F_TARGET_ROLL     = 0;
  localparam int F_TARGET_PITCH    = 1;
  localparam int F_TARGET_YAW      = 2;
  localparam int F_TARGET_ALT      = 3;
  localparam int F_MEAS_ROLL       = 4;
  localparam int F_MEAS_PITCH      = 5;
  localparam int F_MEAS_YAW        = 6;
  localparam int F_MEAS_ROLL_RATE  = 7;
  localparam int F_MEAS_PITCH_RATE = 8;
  localparam int F_MEAS_YAW_RATE   = 9;
  localparam int F_MEAS_ALT        = 10;
  localparam int F_MEAS_CLIMB      = 11;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTITUDE_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_PROP_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_DERIV_GAIN  = 3'd6;

  // Gain reset values with 16 fraction bits; rescaled to the configured format.
  localparam logic [63:0] ATTITUDE_GAIN_RST_Q16   = 64'd294912;
  localparam logic [63:0] RATE_PROP_GAIN_RST_Q16  = 64'd9830;
  localparam logic [63:0] RATE_INTEG_GAIN_RST_Q16 = 64'd655;
  localparam logic [63:0] RATE_DERIV_GAIN_RST_Q16 = 64'd131;
  localparam logic [63:0] ALT_PROP_GAIN_RST_Q16   = 64'd65536;
  localparam logic [63:0] ALT_DERIV_GAIN_RST_Q16  = 64'd32768;
  // Integrator limit reset, 50.0 with 12 fraction bits.
  localparam logic [63:0] INTEG_LIMIT_RST         = 64'd204800;

  // Axis numbering used by the sequencer.
  localparam logic [1:0] AXIS_ROLL  = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SP,
    ST_RND,
    ST_ERR,
    ST_P,
    ST_I,
    ST_D,
    ST_TP,
    ST_TD,
    ST_THR,
    ST_MIX
  } seq_state_e;

  typedef enum logic [2:0] {
    GS_ATTITUDE,
    GS_RATE_P,
    GS_RATE_I,
    GS_RATE_D,
    GS_ALT_P,
    GS_ALT_D
  } gain_sel_e;

  typedef enum logic [2:0] {
    OS_ANGLE_ERR,
    OS_ERR,
    OS_INTEG,
    OS_NEG_RATE,
    OS_ALT_ERR,
    OS_NEG_CLIMB
  } opnd_sel_e;

  typedef struct packed {
    logic       in_ready;
    logic       mac_en;
    logic       mac_clr;
    gain_sel_e  gain_sel;
    opnd_sel_e  opnd_sel;
    logic [1:0] axis;
    logic       ld_sp;
    logic       ld_err;
    logic       upd_integ;
    logic       st_axis;
    logic [1:0] st_idx;
    logic       st_thrust;
    logic       out_load;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/quadrotor_cascaded_pid_mixer.sv =====
`default_nettype none

// Cascaded PID attitude and altitude controller with an X-frame quadrotor mixer.
// Each slave beat is one control period carrying twelve signed fixed-point values
// (12 fraction bits) and each master beat returns four 16-bit motor commands, where
// 65535 means full thrust. For roll, pitch and yaw a proportional angle loop turns
// the angle error into a rate setpoint, and a PI rate loop with a D term on the
// negative measured rate follows; its three integrators persist across beats and
// are clamped to plus or minus integ_limit. A PD altitude loop gives the base
// thrust. All products run through one shared multiply-accumulate unit under a
// small sequencer, and a new beat is taken only after the previous result has
// been loaded. The result sits in an output register, so a stalled master only
// delays the final mixing step. Gains are unsigned with GAIN_FRAC_BITS fraction
// bits and four integer bits. Configuration is to be written through the plain
// write port while the block is idle; the block itself does not enforce this.
module quadrotor_cascaded_pid_mixer #(
  parameter int VALUE_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [qcpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [((GAIN_FRAC_BITS + qcpm_pkg::GAIN_INT_BITS) > (VALUE_WIDTH - 1) ?
                      (GAIN_FRAC_BITS + qcpm_pkg::GAIN_INT_BITS) :
                      (VALUE_WIDTH - 1))-1:0] cfg_data_i,

  // Slave side.
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // Fields from bit 0 up, VALUE_WIDTH bits each: target_roll, target_pitch,
  // target_yaw, target_alt, meas_roll, meas_pitch, meas_yaw, meas_roll_rate,
  // meas_pitch_rate, meas_yaw_rate, meas_alt, meas_climb; zero padded to bytes.
  input  wire logic [((qcpm_pkg::NUM_IN_FIELDS * VALUE_WIDTH + 7) / 8) * 8 - 1:0]
                    s_axis_tdata,

  // Master side.
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // Fields from bit 0 up, 16 bits each: cmd_front_left, cmd_front_right,
  // cmd_back_left, cmd_back_right.
  output logic [qcpm_pkg::NUM_OUT_FIELDS*qcpm_pkg::CMD_W-1:0] m_axis_tdata
);
  import qcpm_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int GW     = GAIN_FRAC_BITS + GAIN_INT_BITS;
  localparam int CLIP_W = VALUE_FRAC_BITS + 1;
  localparam int SCL_W  = CLIP_W + CMD_W;

  localparam logic signed [VW+1:0] MIX_ONE =
    {{(VW+1-VALUE_FRAC_BITS){1'b0}}, 1'b1, {VALUE_FRAC_BITS{1'b0}}};
  localparam logic [SCL_W-1:0] CMD_HALF =
    {{(SCL_W-VALUE_FRAC_BITS){1'b0}}, 1'b1, {(VALUE_FRAC_BITS-1){1'b0}}};

  ctrl_t ctrl;
  logic  start;
  logic  out_free;

  logic [GW-1:0]   att_gain, rate_p_gain, rate_i_gain, rate_d_gain, alt_p_gain, alt_d_gain;
  logic [VW-2:0]   integ_limit;

  // Input item, held for the whole computation.
  logic signed [VW-1:0] in_q [NUM_IN_FIELDS];

  logic signed [VW-1:0] sp_q, err_q;
  logic signed [VW-1:0] roll_integ_q, pitch_integ_q, yaw_integ_q;
  logic signed [VW-1:0] roll_q, pitch_q, yaw_q, thrust_q;

  logic [NUM_OUT_FIELDS*CMD_W-1:0] out_data_q;
  logic                            out_valid_q;

  logic signed [VW-1:0] tgt, meas, rate, integ_cur;
  logic signed [VW:0]   angle_err, neg_rate, alt_err, neg_climb, err_ext, integ_ext;
  logic signed [VW:0]   err_diff, integ_sum, lim_pos, lim_neg;
  logic signed [VW-1:0] err_next, integ_next;

  logic [GW-1:0]        mac_gain;
  logic signed [VW:0]   mac_opnd;
  logic signed [VW-1:0] mac_rnd;

  logic signed [VW+1:0] mix_fl, mix_fr, mix_bl, mix_br;

  assign start         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = ctrl.in_ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  qcpm_cfg_regs #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .att_gain_o    (att_gain),
    .rate_p_gain_o (rate_p_gain),
    .rate_i_gain_o (rate_i_gain),
    .rate_d_gain_o (rate_d_gain),
    .alt_p_gain_o  (alt_p_gain),
    .alt_d_gain_o  (alt_d_gain),
    .integ_limit_o (integ_limit)
  );

  qcpm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  qcpm_mac #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .en_i   (ctrl.mac_en),
    .clr_i  (ctrl.mac_clr),
    .gain_i (mac_gain),
    .opnd_i (mac_opnd),
    .rnd_o  (mac_rnd)
  );

  // Capture the beat; the fields are unpacked once here.
  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int i = 0; i < NUM_IN_FIELDS; i++) begin
        in_q[i] <= s_axis_tdata[i*VW +: VW];
      end
    end
  end

  // Per-axis operands, chosen by the axis the sequencer is working on.
  always_comb begin
    case (ctrl.axis)
      AXIS_PITCH: begin
        tgt       = in_q[F_TARGET_PITCH];
        meas      = in_q[F_MEAS_PITCH];
        rate      = in_q[F_MEAS_PITCH_RATE];
        integ_cur = pitch_integ_q;
      end
      AXIS_YAW: begin
        tgt       = in_q[F_TARGET_YAW];
        meas      = in_q[F_MEAS_YAW];
        rate      = in_q[F_MEAS_YAW_RATE];
        integ_cur = yaw_integ_q;
      end
      default: begin
        tgt       = in_q[F_TARGET_ROLL];
        meas      = in_q[F_MEAS_ROLL];
        rate      = in_q[F_MEAS_ROLL_RATE];
        integ_cur = roll_integ_q;
      end
    endcase
  end

  // Differences and negations get one extra bit so they never wrap.
  assign angle_err = {tgt[VW-1], tgt} - {meas[VW-1], meas};
  assign neg_rate  = -{rate[VW-1], rate};
  assign alt_err   = {in_q[F_TARGET_ALT][VW-1], in_q[F_TARGET_ALT]}
                   - {in_q[F_MEAS_ALT][VW-1], in_q[F_MEAS_ALT]};
  assign neg_climb = -{in_q[F_MEAS_CLIMB][VW-1], in_q[F_MEAS_CLIMB]};
  assign err_ext   = {err_q[VW-1], err_q};
  assign integ_ext = {integ_cur[VW-1], integ_cur};

  always_comb begin
    case (ctrl.gain_sel)
      GS_RATE_P: mac_gain = rate_p_gain;
      GS_RATE_I: mac_gain = rate_i_gain;
      GS_RATE_D: mac_gain = rate_d_gain;
      GS_ALT_P:  mac_gain = alt_p_gain;
      GS_ALT_D:  mac_gain = alt_d_gain;
      default:   mac_gain = att_gain;
    endcase
  end

  always_comb begin
    case (ctrl.opnd_sel)
      OS_ERR:       mac_opnd = err_ext;
      OS_INTEG:     mac_opnd = integ_ext;
      OS_NEG_RATE:  mac_opnd = neg_rate;
      OS_ALT_ERR:   mac_opnd = alt_err;
      OS_NEG_CLIMB: mac_opnd = neg_climb;
      default:      mac_opnd = angle_err;
    endcase
  end

  // Rate error: setpoint minus measured rate, saturated to the value range.
  assign err_diff = {sp_q[VW-1], sp_q} - {rate[VW-1], rate};
  always_comb begin
    if (err_diff[VW] != err_diff[VW-1]) begin
      err_next = {err_diff[VW], {(VW-1){!err_diff[VW]}}};
    end else begin
      err_next = err_diff[VW-1:0];
    end
  end

  // Integrator step with a symmetric clamp. A zero limit pins the integrator at zero.
  assign integ_sum = integ_ext + err_ext;
  assign lim_pos   = {2'b00, integ_limit};
  assign lim_neg   = -lim_pos;
  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_next = lim_pos[VW-1:0];
    end else if (integ_sum < lim_neg) begin
      integ_next = lim_neg[VW-1:0];
    end else begin
      integ_next = integ_sum[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_sp) begin
      sp_q <= mac_rnd;
    end
    if (ctrl.ld_err) begin
      err_q <= err_next;
    end
    if (ctrl.st_axis) begin
      case (ctrl.st_idx)
        AXIS_PITCH: pitch_q <= mac_rnd;
        AXIS_YAW:   yaw_q   <= mac_rnd;
        default:    roll_q  <= mac_rnd;
      endcase
    end
    if (ctrl.st_thrust) begin
      thrust_q <= mac_rnd;
    end
  end

  // The integrators are controller state and start from zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_integ_q  <= '0;
      pitch_integ_q <= '0;
      yaw_integ_q   <= '0;
    end else if (ctrl.upd_integ) begin
      case (ctrl.axis)
        AXIS_PITCH: pitch_integ_q <= integ_next;
        AXIS_YAW:   yaw_integ_q   <= integ_next;
        default:    roll_integ_q  <= integ_next;
      endcase
    end
  end

  // X mixer. Each motor sum gets two guard bits, since four saturated terms are added.
  function automatic logic signed [VW+1:0] sx(input logic signed [VW-1:0] v);
    return {{2{v[VW-1]}}, v};
  endfunction

  // Clamp to 0..1.0 and scale to 0..65535 with round half up: m * 65535 = (m << 16) - m.
  function automatic logic [CMD_W-1:0] to_cmd(input logic signed [VW+1:0] m);
    logic [CLIP_W-1:0] c;
    logic [SCL_W-1:0]  scaled;
    if (m[VW+1]) begin
      c = '0;
    end else if (m > MIX_ONE) begin
      c = MIX_ONE[CLIP_W-1:0];
    end else begin
      c = m[CLIP_W-1:0];
    end
    scaled = {c, {CMD_W{1'b0}}} - {{CMD_W{1'b0}}, c} + CMD_HALF;
    return scaled[VALUE_FRAC_BITS +: CMD_W];
  endfunction

  assign mix_fl = sx(thrust_q) + sx(pitch_q) + sx(roll_q) - sx(yaw_q);
  assign mix_fr = sx(thrust_q) + sx(pitch_q) - sx(roll_q) + sx(yaw_q);
  assign mix_bl = sx(thrust_q) - sx(pitch_q) + sx(roll_q) + sx(yaw_q);
  assign mix_br = sx(thrust_q) - sx(pitch_q) - sx(roll_q) - sx(yaw_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= {to_cmd(mix_br), to_cmd(mix_bl), to_cmd(mix_fr), to_cmd(mix_fl)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Once a beat is taken the block is busy for the whole computation.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("slave ready right after an accepted beat");

  // A result is loaded only when the output register is free or being drained.
  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result loaded over a pending beat");

  // Master valid only rises from a mixer load.
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl.out_load))
    else $error("master valid rose without a result load");

  // No new beat is taken while the mixer still waits to deliver.
  a_no_accept_while_mixing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.st_thrust |=> !s_axis_tready)
    else $error("slave ready before the result was delivered");

endmodule

`default_nettype wire

// ===== rtl/qcpm_cfg_regs.sv =====
`default_nettype none

module qcpm_cfg_regs #(
  parameter int VALUE_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [qcpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [((GAIN_FRAC_BITS + qcpm_pkg::GAIN_INT_BITS) > (VALUE_WIDTH - 1) ?
                      (GAIN_FRAC_BITS + qcpm_pkg::GAIN_INT_BITS) :
                      (VALUE_WIDTH - 1))-1:0] cfg_data_i,
  output logic [GAIN_FRAC_BITS+qcpm_pkg::GAIN_INT_BITS-1:0] att_gain_o,
  output logic [GAIN_FRAC_BITS+qcpm_pkg::GAIN_INT_BITS-1:0] rate_p_gain_o,
  output logic [GAIN_FRAC_BITS+qcpm_pkg::GAIN_INT_BITS-1:0] rate_i_gain_o,
  output logic [GAIN_FRAC_BITS+qcpm_pkg::GAIN_INT_BITS-1:0] rate_d_gain_o,
  output logic [GAIN_FRAC_BITS+qcpm_pkg::GAIN_INT_BITS-1:0] alt_p_gain_o,
  output logic [GAIN_FRAC_BITS+qcpm_pkg::GAIN_INT_BITS-1:0] alt_d_gain_o,
  output logic [VALUE_WIDTH-2:0]                             integ_limit_o
);
  import qcpm_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + GAIN_INT_BITS;

  // Rescale the 16-fraction-bit defaults to this gain format, rounding half up.
  localparam logic [63:0] RST_ATT = ((ATTITUDE_GAIN_RST_Q16 << GAIN_FRAC_BITS) + 64'd32768) >> 16;
  localparam logic [63:0] RST_RP  = ((RATE_PROP_GAIN_RST_Q16 << GAIN_FRAC_BITS) + 64'd32768) >> 16;
  localparam logic [63:0] RST_RI  = ((RATE_INTEG_GAIN_RST_Q16 << GAIN_FRAC_BITS) + 64'd32768) >> 16;
  localparam logic [63:0] RST_RD  = ((RATE_DERIV_GAIN_RST_Q16 << GAIN_FRAC_BITS) + 64'd32768) >> 16;
  localparam logic [63:0] RST_AP  = ((ALT_PROP_GAIN_RST_Q16 << GAIN_FRAC_BITS) + 64'd32768) >> 16;
  localparam logic [63:0] RST_AD  = ((ALT_DERIV_GAIN_RST_Q16 << GAIN_FRAC_BITS) + 64'd32768) >> 16;

  logic [GW-1:0]          att_q, rp_q, ri_q, rd_q, ap_q, ad_q;
  logic [VALUE_WIDTH-2:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q <= RST_ATT[GW-1:0];
      rp_q  <= RST_RP[GW-1:0];
      ri_q  <= RST_RI[GW-1:0];
      rd_q  <= RST_RD[GW-1:0];
      ap_q  <= RST_AP[GW-1:0];
      ad_q  <= RST_AD[GW-1:0];
      lim_q <= INTEG_LIMIT_RST[VALUE_WIDTH-2:0];
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATTITUDE_GAIN:   att_q <= cfg_data_i[GW-1:0];
        REG_RATE_PROP_GAIN:  rp_q  <= cfg_data_i[GW-1:0];
        REG_RATE_INTEG_GAIN: ri_q  <= cfg_data_i[GW-1:0];
        REG_RATE_DERIV_GAIN: rd_q  <= cfg_data_i[GW-1:0];
        REG_INTEG_LIMIT:     lim_q <= cfg_data_i[VALUE_WIDTH-2:0];
        REG_ALT_PROP_GAIN:   ap_q  <= cfg_data_i[GW-1:0];
        REG_ALT_DERIV_GAIN:  ad_q  <= cfg_data_i[GW-1:0];
        default: ;
      endcase
    end
  end

  assign att_gain_o    = att_q;
  assign rate_p_gain_o = rp_q;
  assign rate_i_gain_o = ri_q;
  assign rate_d_gain_o = rd_q;
  assign alt_p_gain_o  = ap_q;
  assign alt_d_gain_o  = ad_q;
  assign integ_limit_o = lim_q;

endmodule

`default_nettype wire

// ===== rtl/qcpm_mac.sv =====
`default_nettype none

module qcpm_mac #(
  parameter int VALUE_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                en_i,
  input  wire logic                                                clr_i,
  input  wire logic [GAIN_FRAC_BITS+qcpm_pkg::GAIN_INT_BITS-1:0]  gain_i,
  input  wire logic signed [VALUE_WIDTH:0]                        opnd_i,
  output logic signed [VALUE_WIDTH-1:0]                           rnd_o
);
  import qcpm_pkg::*;

  localparam int GW     = GAIN_FRAC_BITS + GAIN_INT_BITS;
  localparam int PROD_W = GW + VALUE_WIDTH + 2;
  // Up to three products are summed before rounding.
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, 1'b1, {(GAIN_FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  rnd_sum, shifted;

  assign prod  = PROD_W'($signed({1'b0, gain_i})) * PROD_W'(opnd_i);
  assign acc_d = clr_i ? ACC_W'(prod) : acc_q + ACC_W'(prod);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  // Round to nearest with ties upward, then saturate to the value range.
  assign rnd_sum = acc_q + HALF;
  assign shifted = rnd_sum >>> GAIN_FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      rnd_o = SAT_MAX[VALUE_WIDTH-1:0];
    end else if (shifted < SAT_MIN) begin
      rnd_o = SAT_MIN[VALUE_WIDTH-1:0];
    end else begin
      rnd_o = shifted[VALUE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qcpm_seq.sv =====
`default_nettype none

module qcpm_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            out_free_i,
  output qcpm_pkg::ctrl_t      ctrl_o
);
  import qcpm_pkg::*;

  seq_state_e state_d, state_q;
  logic [1:0] axis_d, axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= AXIS_ROLL;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SP;
          axis_d  = AXIS_ROLL;
        end
      end
      ST_SP:  state_d = ST_RND;
      ST_RND: state_d = ST_ERR;
      ST_ERR: state_d = ST_P;
      ST_P:   state_d = ST_I;
      ST_I:   state_d = ST_D;
      ST_D: begin
        if (axis_q == AXIS_YAW) begin
          state_d = ST_TP;
        end else begin
          state_d = ST_SP;
          axis_d  = axis_q + 2'd1;
        end
      end
      ST_TP:  state_d = ST_TD;
      ST_TD:  state_d = ST_THR;
      ST_THR: state_d = ST_MIX;
      ST_MIX: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.gain_sel = GS_ATTITUDE;
    ctrl_o.opnd_sel = OS_ANGLE_ERR;
    ctrl_o.axis     = axis_q;
    case (state_q)
      ST_IDLE: ctrl_o.in_ready = 1'b1;
      ST_SP: begin
        // The previous axis result is still in the accumulator on this edge.
        ctrl_o.mac_en   = 1'b1;
        ctrl_o.mac_clr  = 1'b1;
        ctrl_o.st_axis  = (axis_q != AXIS_ROLL);
        ctrl_o.st_idx   = axis_q - 2'd1;
      end
      ST_RND: ctrl_o.ld_sp  = 1'b1;
      ST_ERR: ctrl_o.ld_err = 1'b1;
      ST_P: begin
        ctrl_o.mac_en    = 1'b1;
        ctrl_o.mac_clr   = 1'b1;
        ctrl_o.gain_sel  = GS_RATE_P;
        ctrl_o.opnd_sel  = OS_ERR;
        ctrl_o.upd_integ = 1'b1;
      end
      ST_I: begin
        ctrl_o.mac_en   = 1'b1;
        ctrl_o.gain_sel = GS_RATE_I;
        ctrl_o.opnd_sel = OS_INTEG;
      end
      ST_D: begin
        ctrl_o.mac_en   = 1'b1;
        ctrl_o.gain_sel = GS_RATE_D;
        ctrl_o.opnd_sel = OS_NEG_RATE;
      end
      ST_TP: begin
        ctrl_o.mac_en   = 1'b1;
        ctrl_o.mac_clr  = 1'b1;
        ctrl_o.gain_sel = GS_ALT_P;
        ctrl_o.opnd_sel = OS_ALT_ERR;
        ctrl_o.st_axis  = 1'b1;
        ctrl_o.st_idx   = AXIS_YAW;
      end
      ST_TD: begin
        ctrl_o.mac_en   = 1'b1;
        ctrl_o.gain_sel = GS_ALT_D;
        ctrl_o.opnd_sel = OS_NEG_CLIMB;
      end
      ST_THR: ctrl_o.st_thrust = 1'b1;
      ST_MIX: ctrl_o.out_load  = out_free_i;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
